### src/sitda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared widths, character codes, types and the binary to BCD step used by
// the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int ValueWidth   = 32;
   localparam int CharWidth    = 6;
   localparam int DigitWidth   = 4;
   localparam int DigitCount   = 10;
   localparam int BcdWidth     = DigitCount * DigitWidth;
   localparam int BitsPerStage = 8;
   localparam int DabbleStages = ValueWidth / BitsPerStage;
   localparam int IndexWidth   = $clog2(DigitCount);
   localparam int Radix        = 10;

   typedef logic [DigitWidth-1:0] digit_type;
   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [CharWidth-1:0]  char_type;

   localparam char_type  DigitBase   = 6'd48;
   localparam char_type  MinusChar   = 6'd45;
   // A digit of five or more is corrected before the shift so that it
   // carries into the next decade once doubled.
   localparam digit_type AdjustLimit = DigitWidth'(Radix / 2);
   localparam digit_type AdjustAdd   = DigitWidth'((1 << DigitWidth) - Radix) >> 1;

   // One converted number on its way to the character serialiser.
   typedef struct packed {
      logic                        negative;
      digit_type [DigitCount-1:0]  digits;
      index_type                   top;
   } conv_type;

   // One shift-and-add-three step: correct every decade, then shift in a bit.
   function automatic logic [BcdWidth-1:0] dabble_step(input logic [BcdWidth-1:0] bcd,
                                                       input logic              in_bit);
      logic [BcdWidth-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DigitCount; d++) begin
         if (adj[d*DigitWidth +: DigitWidth] >= AdjustLimit) begin
            adj[d*DigitWidth +: DigitWidth] = adj[d*DigitWidth +: DigitWidth] + AdjustAdd;
         end
      end
      return {adj[BcdWidth-2:0], in_bit};
   endfunction

endpackage
`default_nettype wire

### src/sitda_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_req_if
// Request channel: one signed integer per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sitda_req_if;
   import sitda_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

### src/sitda_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_rsp_if
// Response channel: one ASCII character per response, with an end marker.
// ----------------------------------------------------------------------------
interface sitda_rsp_if;
   import sitda_pkg::*;

   logic     valid;
   logic     ready;
   char_type character;
   logic     last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

### src/sitda_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_dabble
// Conversion pipeline: sign and magnitude, four stages of eight
// shift-and-add-three steps each, then a leading digit search.
// ----------------------------------------------------------------------------
module sitda_dabble (
   input  logic               clock,
   input  logic               reset,
   sitda_req_if.sink          req_ch,
   output logic               conv_valid,
   output sitda_pkg::conv_type conv,
   input  logic               conv_ready
);
   import sitda_pkg::*;

   logic                  advance;
   logic [DabbleStages:0] valid_ff;
   logic                  neg_ff [DabbleStages+1];
   logic [ValueWidth-1:0] bin_ff [DabbleStages+1];
   logic [BcdWidth-1:0]   bcd_ff [DabbleStages+1];
   logic [ValueWidth-1:0] raw;
   logic [ValueWidth-1:0] mag_in;
   index_type             top_in;
   conv_type              conv_in;
   logic                  conv_valid_ff;
   conv_type              conv_ff;

   // The whole pipeline holds when its last stage is full and not taken.
   assign advance      = !conv_valid_ff || conv_ready;
   assign req_ch.ready = advance;

   // The most negative value negates to itself, which read unsigned is 2^31.
   assign raw    = ValueWidth'(req_ch.value);
   assign mag_in = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff[0] <= raw[ValueWidth-1];
         bin_ff[0] <= mag_in;
         bcd_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= DabbleStages; k++) begin : g_stage
      logic [BcdWidth-1:0]   bcd_in;
      logic [ValueWidth-1:0] bin_in;

      always_comb begin
         bcd_in = bcd_ff[k-1];
         bin_in = bin_ff[k-1];
         for (int s = 0; s < BitsPerStage; s++) begin
            bcd_in = dabble_step(bcd_in, bin_in[ValueWidth-1]);
            bin_in = {bin_in[ValueWidth-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            neg_ff[k] <= neg_ff[k-1];
            bin_ff[k] <= bin_in;
            bcd_ff[k] <= bcd_in;
         end
      end
   end

   // Highest non-zero decade; zero keeps index 0 so that a single '0' leaves.
   always_comb begin
      top_in = '0;
      for (int d = 0; d < DigitCount; d++) begin
         if (bcd_ff[DabbleStages][d*DigitWidth +: DigitWidth] != '0) begin
            top_in = index_type'(d);
         end
      end
   end

   always_comb begin
      conv_in.negative = neg_ff[DabbleStages];
      conv_in.digits   = bcd_ff[DabbleStages];
      conv_in.top      = top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_valid_ff <= 1'b0;
      end else if (advance) begin
         conv_valid_ff <= valid_ff[DabbleStages];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         conv_ff <= conv_in;
      end
   end

   assign conv_valid = conv_valid_ff;
   assign conv       = conv_ff;

endmodule
`default_nettype wire

### src/sitda_serial.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_serial
// Character serialiser: holds one converted number and hands out the sign
// and then its digits, most significant first, one per response.
// ----------------------------------------------------------------------------
module sitda_serial (
   input  logic                clock,
   input  logic                reset,
   input  logic                conv_valid,
   input  sitda_pkg::conv_type conv,
   output logic                conv_ready,
   sitda_rsp_if.source         rsp_ch
);
   import sitda_pkg::*;

   logic                       busy_ff;
   logic                       sign_ff;
   index_type                  idx_ff;
   digit_type [DigitCount-1:0] digits_ff;
   logic                       last_char;
   logic                       load;

   assign last_char  = !sign_ff && (idx_ff == '0);
   // The next number is taken in the same cycle as the last character leaves.
   assign conv_ready = !busy_ff || (rsp_ch.ready && last_char);
   assign load       = conv_valid && conv_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sign_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         sign_ff <= conv.negative;
         idx_ff  <= conv.top;
      end else if (busy_ff && rsp_ch.ready) begin
         if (sign_ff) begin
            sign_ff <= 1'b0;
         end else if (idx_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= index_type'(idx_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= conv.digits;
      end
   end

   assign rsp_ch.valid     = busy_ff;
   assign rsp_ch.character = sign_ff ? MinusChar
                                     : char_type'(DigitBase + char_type'(digits_ff[idx_ff]));
   assign rsp_ch.last      = last_char;

endmodule
`default_nettype wire

### src/signed_int_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per response, sign first, no leading zeros, last character marked.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                       Handshake
//  req_ch    in         value (32-bit signed)         valid / ready
//  rsp_ch    out        character (6 bits), last      valid / ready
//
// A request passes six register stages (sign and magnitude, four BCD stages
// of eight bits each, leading digit search) and is then loaded into the
// serialiser. An idle serialiser loads it as soon as the last stage holds it,
// and offers its first character from its own registers.
// The serialiser gives one character per cycle while the response side is
// ready, 1 to 11 characters per request, and takes the next number in the
// same cycle as the last character leaves. A response stall holds it, and
// the pipeline once its last stage is full; reset empties both of them.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   sitda_req_if.sink   req_ch,
   sitda_rsp_if.source rsp_ch
);
   import sitda_pkg::*;

   logic     conv_valid;
   logic     conv_ready;
   conv_type conv;

   sitda_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .conv_valid (conv_valid),
      .conv       (conv),
      .conv_ready (conv_ready)
   );

   sitda_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .conv_valid (conv_valid),
      .conv       (conv),
      .conv_ready (conv_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire
